// File: hdl/sil_pkg.sv
// Shared types, codes and the ordering compare for the sorted integer list engine.
package sil_pkg;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_READ   = 3'd3,
    OP_SEARCH = 3'd4,
    OP_SORT   = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_POP_RD,
    S_POP_WR,
    S_READ_CHK,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SORT_RD,
    S_SORT_KEY,
    S_SORT_CRD,
    S_SORT_CCHK,
    S_FIN
  } state_t;

  // True when a strictly precedes b in the selected order.
  function automatic logic precedes(input logic signed [31:0] a,
                                    input logic signed [31:0] b,
                                    input logic desc);
    logic r;
    if (desc) r = (a > b);
    else      r = (a < b);
    return r;
  endfunction

endpackage

// File: hdl/sil_mem.sv
// Element store: synchronous memory, one write and one registered read port.
module sil_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/sorted_integer_list_engine.sv
// Top level: command sequencer for the sorted integer list over one memory.
//
// One command is taken when start is high and busy is low; busy then stays high
// until the single result has been shown with done for exactly one cycle, which
// the receiver must take there and then. Every step of a walk has a read state
// and a check or write state, because the element store has one registered read
// port. Ordered insert scans for its place; push and insert then shift entries
// up to open a gap, pop shifts them down, search walks from the front for the
// first equal entry, and sort is an insertion sort through the store.
// No clearing pass follows reset; the block is ready at once.
module sorted_integer_list_engine import sil_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation,
  input  logic signed [31:0] value,
  input  logic [7:0]         position,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] element,
  output logic [7:0]         found_position,
  output logic [8:0]         entry_count
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  state_t state, state_next;
  logic order_desc;
  logic [CW-1:0] cnt, cnt_next, idx, idx_next, jdx, jdx_next, tgt, tgt_next;
  logic signed [31:0] val, val_next, key, key_next;
  logic [1:0] stat, stat_next;
  logic signed [31:0] elem, elem_next;
  logic [7:0] fpos, fpos_next;

  logic mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata, mem_rdata;
  logic signed [31:0] rd;

  assign rd = mem_rdata;

  sil_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
    .rd_en(mem_re), .rd_addr(mem_raddr), .rd_data(mem_rdata)
  );

  // Hold the order register
  always_ff @(posedge clk) begin
    if (rst) begin
      order_desc <= 1'b0;
    end else if (cfg_wr_en) begin
      order_desc <= cfg_wr_data;
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    idx  <= idx_next;
    jdx  <= jdx_next;
    tgt  <= tgt_next;
    val  <= val_next;
    key  <= key_next;
    stat <= stat_next;
    elem <= elem_next;
    fpos <= fpos_next;
  end

  // Sequence the memory walks
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    jdx_next   = jdx;
    tgt_next   = tgt;
    val_next   = val;
    key_next   = key;
    stat_next  = stat;
    elem_next  = elem;
    fpos_next  = fpos;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          val_next  = value;
          stat_next = ST_DONE;
          elem_next = '0;
          fpos_next = '0;
          state_next = S_FIN;
          case (operation)
            OP_PUSH: begin
              if (cnt == CW'(DEPTH)) begin
                stat_next = ST_FULL;
              end else begin
                tgt_next   = '0;
                idx_next   = cnt;
                state_next = S_SHIFT_RD;
              end
            end
            OP_INSERT: begin
              if (cnt == CW'(DEPTH)) begin
                stat_next = ST_FULL;
              end else if (cnt == '0) begin
                tgt_next   = '0;
                idx_next   = cnt;
                state_next = S_SHIFT_RD;
              end else begin
                idx_next   = '0;
                state_next = S_SCAN_RD;
              end
            end
            OP_POP: begin
              if (cnt == '0) begin
                stat_next = ST_MISS;
              end else begin
                idx_next   = CW'(1);
                state_next = S_POP_RD;
              end
            end
            OP_READ: begin
              if (CMPW'(position) >= CMPW'(cnt)) begin
                stat_next = ST_MISS;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(CMPW'(position));
                state_next = S_READ_CHK;
              end
            end
            OP_SEARCH: begin
              stat_next  = ST_MISS;
              idx_next   = '0;
              state_next = S_SRCH_RD;
            end
            OP_SORT: begin
              idx_next   = CW'(1);
              state_next = S_SORT_RD;
            end
            OP_CLEAR: begin
              cnt_next = '0;
            end
            default: begin
              stat_next = ST_MISS;
            end
          endcase
        end
      end

      // Find the insert place
      S_SCAN_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = idx[AW-1:0];
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (idx == '0) begin
          if (precedes(val, rd, order_desc)) begin
            tgt_next   = '0;
            idx_next   = cnt;
            state_next = S_SHIFT_RD;
          end else if (CW'(1) < cnt) begin
            idx_next   = CW'(1);
            state_next = S_SCAN_RD;
          end else begin
            tgt_next   = CW'(1);
            idx_next   = cnt;
            state_next = S_SHIFT_RD;
          end
        end else if (precedes(rd, val, order_desc)) begin
          if (idx + CW'(1) < cnt) begin
            idx_next   = idx + CW'(1);
            state_next = S_SCAN_RD;
          end else begin
            tgt_next   = idx + CW'(1);
            idx_next   = cnt;
            state_next = S_SHIFT_RD;
          end
        end else begin
          tgt_next   = idx;
          idx_next   = cnt;
          state_next = S_SHIFT_RD;
        end
      end

      // Open a gap at the target and drop the value in
      S_SHIFT_RD: begin
        if (idx > tgt) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(idx - CW'(1));
          state_next = S_SHIFT_WR;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = tgt[AW-1:0];
          mem_wdata  = val;
          cnt_next   = cnt + CW'(1);
          state_next = S_FIN;
        end
      end
      S_SHIFT_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx[AW-1:0];
        mem_wdata  = rd;
        idx_next   = idx - CW'(1);
        state_next = S_SHIFT_RD;
      end

      // Close the gap at the front
      S_POP_RD: begin
        if (idx < cnt) begin
          mem_re     = 1'b1;
          mem_raddr  = idx[AW-1:0];
          state_next = S_POP_WR;
        end else begin
          cnt_next   = cnt - CW'(1);
          state_next = S_FIN;
        end
      end
      S_POP_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = AW'(idx - CW'(1));
        mem_wdata  = rd;
        idx_next   = idx + CW'(1);
        state_next = S_POP_RD;
      end

      S_READ_CHK: begin
        elem_next  = rd;
        state_next = S_FIN;
      end

      // Walk for the first equal entry
      S_SRCH_RD: begin
        if (idx < cnt) begin
          mem_re     = 1'b1;
          mem_raddr  = idx[AW-1:0];
          state_next = S_SRCH_CHK;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SRCH_CHK: begin
        if (rd == val) begin
          stat_next  = ST_DONE;
          elem_next  = val;
          fpos_next  = 8'(idx);
          state_next = S_FIN;
        end else begin
          idx_next   = idx + CW'(1);
          state_next = S_SRCH_RD;
        end
      end

      // Insertion sort: take a key, sift it towards the front
      S_SORT_RD: begin
        if (idx < cnt) begin
          mem_re     = 1'b1;
          mem_raddr  = idx[AW-1:0];
          state_next = S_SORT_KEY;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SORT_KEY: begin
        key_next   = rd;
        jdx_next   = idx;
        state_next = S_SORT_CRD;
      end
      S_SORT_CRD: begin
        if (jdx != '0) begin
          mem_re     = 1'b1;
          mem_raddr  = AW'(jdx - CW'(1));
          state_next = S_SORT_CCHK;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = '0;
          mem_wdata  = key;
          idx_next   = idx + CW'(1);
          state_next = S_SORT_RD;
        end
      end
      S_SORT_CCHK: begin
        mem_we    = 1'b1;
        mem_waddr = jdx[AW-1:0];
        if (precedes(key, rd, order_desc)) begin
          mem_wdata  = rd;
          jdx_next   = jdx - CW'(1);
          state_next = S_SORT_CRD;
        end else begin
          mem_wdata  = key;
          idx_next   = idx + CW'(1);
          state_next = S_SORT_RD;
        end
      end

      S_FIN: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Drive the result ports
  assign busy           = (state != S_IDLE);
  assign done           = (state == S_FIN);
  assign status         = stat;
  assign element        = elem;
  assign found_position = fpos;
  assign entry_count    = 9'(cnt);

endmodule

// File: hdl/sil_checker.sv
// Port-level checks for the sorted integer list engine, bound to the top level.
module sil_checker import sil_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         status,
  input logic signed [31:0] element,
  input logic [7:0]         found_position
);

  // A taken command makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("command not taken");

  // A result transfer falls within a busy period
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result while idle");

  // The block frees up right after a result
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after result");

  // Failed commands carry no element or position
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_DONE |-> element == 0 && found_position == 0)
    else $error("failed result carries data");

  // Status code stays within its set
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status == ST_DONE || status == ST_MISS || status == ST_FULL)
    else $error("bad status");

endmodule

bind sorted_integer_list_engine sil_checker u_sil_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .element(element), .found_position(found_position)
);

// File: verif/sorted_integer_list_engine_test.sv
// Self-checking testbench for the sorted integer list engine: directed table, then random commands.
`timescale 1ns / 1ps

module sorted_integer_list_engine_test;
  import sil_pkg::*;

  localparam int LIST_DEPTH = 256;
  localparam logic [2:0] OP_UNUSED = 3'd7;

  typedef struct {
    logic [1:0]         st;
    logic signed [31:0] el;
    logic [7:0]         fp;
    logic [8:0]         cnt;
  } list_result_t;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] v;
    logic [7:0]         p;
    bit                 typed;
    logic [1:0]         st;
    logic signed [31:0] el;
    logic [7:0]         fp;
    logic [8:0]         cnt;
  } directed_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_wr_en;
  logic               cfg_wr_data;
  logic               start;
  logic               busy;
  logic [2:0]         operation;
  logic signed [31:0] value;
  logic [7:0]         position;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic [7:0]         found_position;
  logic [8:0]         entry_count;

  // Shadow copy of the list and its ordering register
  logic signed [31:0] shadow_list [LIST_DEPTH];
  int                 shadow_total;
  bit                 shadow_desc;

  list_result_t       pending_results [$];
  int                 error_count;
  int                 items_sent;
  bit                 no_idle;

  // Known values first: the empty list, the unused code and known extremes, then duplicates and a sort
  directed_row_t directed_rows [20] = '{
    '{OP_POP,    32'sd0,        8'd0,   1, ST_MISS, 32'sd0,        8'd0, 9'd0},
    '{OP_READ,   32'sd0,        8'd0,   1, ST_MISS, 32'sd0,        8'd0, 9'd0},
    '{OP_SEARCH, 32'sd0,        8'd0,   1, ST_MISS, 32'sd0,        8'd0, 9'd0},
    '{OP_UNUSED, 32'sd0,        8'd0,   1, ST_MISS, 32'sd0,        8'd0, 9'd0},
    '{OP_INSERT, 32'h7fffffff,  8'd255, 1, ST_DONE, 32'sd0,        8'd0, 9'd1},
    '{OP_INSERT, 32'h80000000,  8'd0,   1, ST_DONE, 32'sd0,        8'd0, 9'd2},
    '{OP_READ,   32'sd0,        8'd0,   1, ST_DONE, 32'h80000000,  8'd0, 9'd2},
    '{OP_READ,   32'sd0,        8'd1,   1, ST_DONE, 32'h7fffffff,  8'd0, 9'd2},
    '{OP_READ,   32'sd0,        8'd2,   1, ST_MISS, 32'sd0,        8'd0, 9'd2},
    '{OP_INSERT, 32'sd0,        8'd0,   0, ST_DONE, 32'sd0,        8'd0, 9'd0},
    '{OP_PUSH,   32'hffffffff,  8'd0,   0, ST_DONE, 32'sd0,        8'd0, 9'd0},
    '{OP_INSERT, 32'sd0,        8'd0,   0, ST_DONE, 32'sd0,        8'd0, 9'd0},
    '{OP_SEARCH, 32'sd0,        8'd0,   0, ST_DONE, 32'sd0,        8'd0, 9'd0},
    '{OP_SEARCH, 32'hffffffff,  8'd0,   0, ST_DONE, 32'sd0,        8'd0, 9'd0},
    '{OP_SORT,   32'sd0,        8'd0,   0, ST_DONE, 32'sd0,        8'd0, 9'd0},
    '{OP_READ,   32'sd0,        8'd255, 1, ST_MISS, 32'sd0,        8'd0, 9'd5},
    '{OP_POP,    32'sd0,        8'd0,   0, ST_DONE, 32'sd0,        8'd0, 9'd0},
    '{OP_SEARCH, 32'h7fffffff,  8'd0,   0, ST_DONE, 32'sd0,        8'd0, 9'd0},
    '{OP_CLEAR,  32'sd0,        8'd0,   1, ST_DONE, 32'sd0,        8'd0, 9'd0},
    '{OP_POP,    32'sd0,        8'd0,   1, ST_MISS, 32'sd0,        8'd0, 9'd0}
  };

  sorted_integer_list_engine #(.DEPTH(LIST_DEPTH)) DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .start(start), .busy(busy), .operation(operation), .value(value),
    .position(position), .done(done), .status(status), .element(element),
    .found_position(found_position), .entry_count(entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Strict ordering test under the shadow register
  function automatic bit ahead_of(logic signed [31:0] a, logic signed [31:0] b);
    return shadow_desc ? (a > b) : (a < b);
  endfunction

  function automatic void place_at(int slot, logic signed [31:0] v);
    for (int i = shadow_total; i > slot; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[slot] = v;
    shadow_total++;
  endfunction

  // Apply one command to the shadow list and return the result it should give
  function automatic list_result_t apply_command(logic [2:0] op, logic signed [31:0] v,
                                                 logic [7:0] p);
    list_result_t r;
    int i;
    int j;
    logic signed [31:0] key;
    r = '{ST_DONE, 32'sd0, 8'd0, 9'd0};
    case (op)
      OP_PUSH: begin
        if (shadow_total >= LIST_DEPTH) r.st = ST_FULL;
        else place_at(0, v);
      end
      OP_INSERT: begin
        if (shadow_total >= LIST_DEPTH) r.st = ST_FULL;
        else if (shadow_total == 0 || ahead_of(v, shadow_list[0])) place_at(0, v);
        else begin
          i = 1;
          while (i < shadow_total && ahead_of(shadow_list[i], v)) i++;
          place_at(i, v);
        end
      end
      OP_POP: begin
        if (shadow_total == 0) r.st = ST_MISS;
        else begin
          for (i = 1; i < shadow_total; i++) shadow_list[i - 1] = shadow_list[i];
          shadow_total--;
        end
      end
      OP_READ: begin
        if (p >= shadow_total) r.st = ST_MISS;
        else r.el = shadow_list[p];
      end
      OP_SEARCH: begin
        r.st = ST_MISS;
        for (i = 0; i < shadow_total; i++) begin
          if (shadow_list[i] == v) begin
            r.st = ST_DONE;
            r.el = v;
            r.fp = i[7:0];
            break;
          end
        end
      end
      OP_SORT: begin
        for (i = 1; i < shadow_total; i++) begin
          key = shadow_list[i];
          j = i;
          while (j > 0 && ahead_of(key, shadow_list[j - 1])) begin
            shadow_list[j] = shadow_list[j - 1];
            j--;
          end
          shadow_list[j] = key;
        end
      end
      OP_CLEAR: shadow_total = 0;
      default: r.st = ST_MISS;
    endcase
    r.cnt = shadow_total[8:0];
    return r;
  endfunction

  // Hold the command until it transfers, then record what it should return
  task automatic issue(logic [2:0] op, logic signed [31:0] v, logic [7:0] p,
                       bit typed = 0, list_result_t want = '{0, 0, 0, 0});
    list_result_t predicted;
    start     <= 1'b1;
    operation <= op;
    value     <= v;
    position  <= p;
    do @(posedge clk); while (busy);
    predicted = apply_command(op, v, p);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Drop start for a random gap: mostly none or short, now and then long
  task automatic sender_gap();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (no_idle || pick < 55) n = 0;
    else if (pick < 90) n = $urandom_range(3, 1);
    else n = $urandom_range(40, 5);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Pause the sender until every outstanding result has arrived
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_order(bit desc);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= desc;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_desc = desc;
  endtask

  function automatic logic signed [31:0] pick_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) return $urandom;
    if (pick < 70 && shadow_total > 0) return shadow_list[$urandom_range(shadow_total - 1)];
    if (pick < 92) return $signed($urandom_range(8)) - 4;
    return pick[0] ? 32'h7fffffff : 32'h80000000;
  endfunction

  function automatic logic [7:0] pick_position();
    if ($urandom_range(9) == 0 || shadow_total == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(shadow_total - 1 + ($urandom_range(3) == 0)));
  endfunction

  // Weighted command mix that keeps the list short
  function automatic logic [2:0] pick_operation();
    int pick;
    pick = $urandom_range(99);
    if (shadow_total > 40) return (pick < 90) ? OP_POP : OP_CLEAR;
    if (pick < 30) return OP_INSERT;
    if (pick < 40) return OP_PUSH;
    if (pick < 53) return OP_POP;
    if (pick < 68) return OP_READ;
    if (pick < 85) return OP_SEARCH;
    if (pick < 93) return OP_SORT;
    if (pick < 97) return OP_CLEAR;
    return OP_UNUSED;
  endfunction

  // Fill to capacity, push against the full list, then probe, sort and empty it
  task automatic fill_phase();
    issue(OP_CLEAR, pick_value(), 8'd0);
    sender_gap();
    for (int k = 0; k < LIST_DEPTH + 4; k++) begin
      issue(($urandom_range(3) == 0) ? OP_PUSH : OP_INSERT, pick_value(), 8'($urandom));
      sender_gap();
    end
    for (int k = 0; k < 12; k++) begin
      issue(($urandom_range(1) == 0) ? OP_READ : OP_SEARCH, pick_value(),
            (k == 0) ? 8'd255 : 8'($urandom_range(255)));
      sender_gap();
    end
    issue(OP_SORT, 32'sd0, 8'd0);
    sender_gap();
    for (int k = 0; k < 6; k++) begin
      issue(OP_READ, 32'sd0, 8'($urandom_range(255)));
      sender_gap();
    end
    issue(OP_CLEAR, 32'sd0, 8'd0);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d count %0d", status, entry_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          error_count++;
        end
        if (element !== want.el) begin
          $error("element: expected %0d, got %0d", want.el, element);
          error_count++;
        end
        if (found_position !== want.fp) begin
          $error("found_position: expected %0d, got %0d", want.fp, found_position);
          error_count++;
        end
        if (entry_count !== want.cnt) begin
          $error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
          error_count++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    list_result_t want;
    int phase;
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    start        = 1'b0;
    operation    = OP_PUSH;
    value        = '0;
    position     = '0;
    shadow_total = 0;
    shadow_desc  = 1'b0;
    error_count  = 0;
    items_sent   = 0;
    no_idle      = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_rows[r]) begin
      want = '{directed_rows[r].st, directed_rows[r].el, directed_rows[r].fp,
               directed_rows[r].cnt};
      issue(directed_rows[r].op, directed_rows[r].v, directed_rows[r].p,
            directed_rows[r].typed, want);
      sender_gap();
    end

    // Random phases, each under a fresh ordering setting
    phase = 0;
    while (items_sent < 1850) begin
      write_order((phase % 4 == 1) ? 1'b1 : (phase % 4 == 3) ? 1'b0 :
                  1'($urandom_range(1)));
      no_idle = ($urandom_range(3) == 0);
      if (phase == 8 || phase == 25) fill_phase();
      else begin
        for (int k = 0; k < 40; k++) begin
          issue(pick_operation(), pick_value(), pick_position());
          sender_gap();
        end
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
hdl/sil_pkg.sv
hdl/sil_mem.sv
hdl/sorted_integer_list_engine.sv
hdl/sil_checker.sv
verif/sorted_integer_list_engine_test.sv
